### hw/rtl/pidaw_pkg.sv
// Shared types, register map and saturating arithmetic helpers for the PID drive core.
`timescale 1ns / 1ps
`default_nettype none

package pidaw_pkg;

  localparam int unsigned CfgAddrWidth = 5;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Register index within the configuration map (byte address is 4 * index).
  typedef enum logic [2:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEG_GAIN    = 3'd1,
    REG_DERIV_GAIN    = 3'd2,
    REG_DERIV_POLE    = 3'd3,
    REG_SAMPLE_PERIOD = 3'd4,
    REG_FF_GAIN       = 3'd5,
    REG_TRIM_OFFSET   = 3'd6,
    REG_DRIVE_MAX     = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] prop_gain;
    logic signed [31:0] integ_step_gain;
    logic signed [31:0] deriv_input_gain;
    logic [16:0]        deriv_pole;
    logic [16:0]        sample_period;
    logic signed [31:0] feedforward_gain;
    logic signed [31:0] trim_offset;
    logic [30:0]        drive_max;
  } cfg_t;

  // Operand pair presented to the shared multiplier.
  typedef enum logic [2:0] {
    MS_PROP,
    MS_POLE,
    MS_DGAIN,
    MS_IGAIN,
    MS_FF,
    MS_AW
  } mul_sel_e;

  // Adder / register update performed by the datapath in one step.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_DIFFS,
    OP_ACC_TRIM,
    OP_DHOLD,
    OP_DERIV,
    OP_INTEG,
    OP_ACC_INT,
    OP_ACC_DER,
    OP_ACC_FF,
    OP_CLAMP,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    dp_op_e   op;
  } dp_cmd_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? S32_MIN : S32_MAX;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return sat33(s);
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    return sat33(s);
  endfunction

  // Q16.16 product: add one half, floor-shift by 16, saturate to 32 bits.
  function automatic logic signed [31:0] rnd_sat(input logic signed [65:0] p);
    logic signed [65:0] r;
    logic signed [31:0] q;
    r = p + 66'sd32768;
    if ((&r[65:47]) || !(|r[65:47])) begin
      q = r[47:16];
    end else begin
      q = r[65] ? S32_MIN : S32_MAX;
    end
    return q;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/pid_antiwindup_dirty_derivative_core.sv
// Top level of the PID drive core: register file, step sequencer and datapath.
`timescale 1ns / 1ps
`default_nettype none

// One control tick per input word: the error feeds a proportional term, a
// trapezoidal integral and a band-limited derivative, plus feedforward on the
// command and a trim offset; the sum is clamped to 0..drive_max and, while the
// integral gain is nonzero, the integral is corrected by back-calculation.
// Ticks are processed one at a time. The result word appears once its tick has
// run through every step (later if the output side stalls), and the next input
// word can be taken in the same cycle that the result word appears. The tick rate
// is set by the single shared multiplier, which forms six products per tick,
// and by the saturating sums, which run in sequence.
// Configuration registers sit at byte addresses 4*i and should be written only
// while no tick is in flight.
module pid_antiwindup_dirty_derivative_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [pidaw_pkg::CfgAddrWidth-1:0] paddr,
  input  wire logic [31:0]                        pwdata,
  output      logic [31:0]                        prdata,
  output      logic                               pready,
  input  wire logic                               in_valid_i,
  output      logic                               in_stall_o,
  input  wire logic signed [31:0]                 commanded_value_i,
  input  wire logic signed [31:0]                 measured_value_i,
  input  wire logic                               clear_history_i,
  output      logic                               out_valid_o,
  input  wire logic                               out_stall_i,
  output      logic [30:0]                        drive_o,
  output      logic                               clamped_o
);
  import pidaw_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;

  pidaw_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pidaw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  pidaw_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .cmd_i             (cmd),
    .commanded_value_i (commanded_value_i),
    .measured_value_i  (measured_value_i),
    .clear_history_i   (clear_history_i),
    .drive_o           (drive_o),
    .clamped_o         (clamped_o)
  );

  // A taken input word closes the input side until its tick is finished.
  a_stall_after_accept : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o
  ) else $error("input not stalled after a word was taken");

  // A tick is committed only when the output register can take its word.
  a_finish_slot_free : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_FINISH) |-> !(out_valid_o && out_stall_i)
  ) else $error("tick committed over a pending output word");

  // Every committed tick presents its word on the next cycle.
  a_finish_valid : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_FINISH) |=> out_valid_o
  ) else $error("committed tick produced no output word");

  // Data load and tick commit never coincide.
  a_load_not_finish : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (cmd.op == OP_NONE) && !cmd.mul_en
  ) else $error("input load overlapped with a datapath step");

endmodule

`default_nettype wire

### hw/rtl/pidaw_regs.sv
// APB-style configuration register file for the PID drive core.
`timescale 1ns / 1ps
`default_nettype none

module pidaw_regs (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [pidaw_pkg::CfgAddrWidth-1:0]   paddr,
  input  wire logic [31:0]                          pwdata,
  output      logic [31:0]                          prdata,
  output      logic                                 pready,
  output      pidaw_pkg::cfg_t                      cfg_o
);
  import pidaw_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[CfgAddrWidth-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_PROP_GAIN:     cfg_d.prop_gain        = pwdata;
        REG_INTEG_GAIN:    cfg_d.integ_step_gain  = pwdata;
        REG_DERIV_GAIN:    cfg_d.deriv_input_gain = pwdata;
        REG_DERIV_POLE:    cfg_d.deriv_pole       = pwdata[16:0];
        REG_SAMPLE_PERIOD: cfg_d.sample_period    = pwdata[16:0];
        REG_FF_GAIN:       cfg_d.feedforward_gain = pwdata;
        REG_TRIM_OFFSET:   cfg_d.trim_offset      = pwdata;
        REG_DRIVE_MAX:     cfg_d.drive_max        = pwdata[30:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PROP_GAIN:     prdata = cfg_q.prop_gain;
      REG_INTEG_GAIN:    prdata = cfg_q.integ_step_gain;
      REG_DERIV_GAIN:    prdata = cfg_q.deriv_input_gain;
      REG_DERIV_POLE:    prdata = {15'd0, cfg_q.deriv_pole};
      REG_SAMPLE_PERIOD: prdata = {15'd0, cfg_q.sample_period};
      REG_FF_GAIN:       prdata = cfg_q.feedforward_gain;
      REG_TRIM_OFFSET:   prdata = cfg_q.trim_offset;
      REG_DRIVE_MAX:     prdata = {1'b0, cfg_q.drive_max};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // Every register resets to zero except drive_max, which resets to 1.0.
      cfg_q <= '{prop_gain:        32'sd0,
                 integ_step_gain:  32'sd0,
                 deriv_input_gain: 32'sd0,
                 deriv_pole:       17'd0,
                 sample_period:    17'd0,
                 feedforward_gain: 32'sd0,
                 trim_offset:      32'sd0,
                 drive_max:        31'd65536};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pidaw_ctrl.sv
// Step sequencer for the PID drive core: issues one datapath command per cycle.
`timescale 1ns / 1ps
`default_nettype none

module pidaw_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      pidaw_pkg::dp_cmd_t cmd_o
);
  import pidaw_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_POLE,
    ST_DGAIN,
    ST_IGAIN,
    ST_FF,
    ST_INTEG,
    ST_ACC_I,
    ST_ACC_D,
    ST_ACC_F,
    ST_CLAMP,
    ST_AW,
    ST_AW_WAIT,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   in_stall_q, in_stall_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   slot_free;

  assign accept      = in_valid_i && !in_stall_q;
  assign slot_free   = !(out_valid_q && out_stall_i);
  assign in_stall_o  = in_stall_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MS_PROP;
    cmd_o.op      = OP_NONE;
    state_d       = state_q;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = accept;
        if (accept) state_d = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_PROP;
        cmd_o.op      = OP_DIFFS;
        state_d       = ST_POLE;
      end
      ST_POLE: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_POLE;
        state_d       = ST_DGAIN;
      end
      ST_DGAIN: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_DGAIN;
        cmd_o.op      = OP_ACC_TRIM;
        state_d       = ST_IGAIN;
      end
      ST_IGAIN: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_IGAIN;
        cmd_o.op      = OP_DHOLD;
        state_d       = ST_FF;
      end
      ST_FF: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_FF;
        cmd_o.op      = OP_DERIV;
        state_d       = ST_INTEG;
      end
      ST_INTEG: begin
        cmd_o.op = OP_INTEG;
        state_d  = ST_ACC_I;
      end
      ST_ACC_I: begin
        cmd_o.op = OP_ACC_INT;
        state_d  = ST_ACC_D;
      end
      ST_ACC_D: begin
        cmd_o.op = OP_ACC_DER;
        state_d  = ST_ACC_F;
      end
      ST_ACC_F: begin
        cmd_o.op = OP_ACC_FF;
        state_d  = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd_o.op = OP_CLAMP;
        state_d  = ST_AW;
      end
      ST_AW: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_AW;
        state_d       = ST_AW_WAIT;
      end
      ST_AW_WAIT: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        // The state update and the output word are committed together, only
        // once the output register is free.
        if (slot_free) begin
          cmd_o.op = OP_FINISH;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_d  = (state_d != ST_IDLE);
    out_valid_d = out_valid_q;
    if (cmd_o.op == OP_FINISH) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_stall_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_stall_q  <= in_stall_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pidaw_dp.sv
// Datapath of the PID drive core: shared multiplier, saturating adder and loop state.
`timescale 1ns / 1ps
`default_nettype none

module pidaw_dp (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pidaw_pkg::cfg_t    cfg_i,
  input  wire pidaw_pkg::dp_cmd_t cmd_i,
  input  wire logic signed [31:0] commanded_value_i,
  input  wire logic signed [31:0] measured_value_i,
  input  wire logic               clear_history_i,
  output      logic [30:0]        drive_o,
  output      logic               clamped_o
);
  import pidaw_pkg::*;

  // Loop state
  logic signed [31:0] prev_q, prev_d;
  logic signed [31:0] integ_q, integ_d;
  logic signed [31:0] deriv_q, deriv_d;

  // Per-tick working registers
  logic signed [31:0] cmd_q, err_q, sa_q, sd_q, acc_q, dtmp_q, diff_q;
  logic [30:0]        drv_q, drive_q;
  logic               clip_q, clamped_q;

  // Shared multiplier with raw and rounded product registers
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q;
  logic signed [31:0] mq_q;

  logic signed [31:0] dmax_s;
  logic               ki_nz;

  assign dmax_s    = {1'b0, cfg_i.drive_max};
  assign ki_nz     = (cfg_i.integ_step_gain != 32'sd0);
  assign drive_o   = drive_q;
  assign clamped_o = clamped_q;

  always_comb begin
    case (cmd_i.mul_sel)
      MS_PROP: begin
        mul_a = {cfg_i.prop_gain[31], cfg_i.prop_gain};
        mul_b = {err_q[31], err_q};
      end
      MS_POLE: begin
        mul_a = {16'd0, cfg_i.deriv_pole};
        mul_b = {deriv_q[31], deriv_q};
      end
      MS_DGAIN: begin
        mul_a = {cfg_i.deriv_input_gain[31], cfg_i.deriv_input_gain};
        mul_b = {sd_q[31], sd_q};
      end
      MS_IGAIN: begin
        mul_a = {cfg_i.integ_step_gain[31], cfg_i.integ_step_gain};
        mul_b = {sa_q[31], sa_q};
      end
      MS_FF: begin
        mul_a = {cfg_i.feedforward_gain[31], cfg_i.feedforward_gain};
        mul_b = {cmd_q[31], cmd_q};
      end
      MS_AW: begin
        mul_a = {16'd0, cfg_i.sample_period};
        mul_b = {diff_q[31], diff_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    // The rounded product is registered from the raw one and holds while it holds.
    mq_q <= rnd_sat(prod_q);
  end

  always_comb begin
    prev_d  = prev_q;
    integ_d = integ_q;
    deriv_d = deriv_q;
    if (cmd_i.load && clear_history_i) begin
      prev_d  = '0;
      integ_d = '0;
      deriv_d = '0;
    end
    case (cmd_i.op)
      OP_DERIV:  deriv_d = sat_add(dtmp_q, mq_q);
      OP_INTEG:  integ_d = sat_add(integ_q, mq_q);
      OP_FINISH: begin
        prev_d = err_q;
        if (ki_nz) integ_d = sat_add(integ_q, mq_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      integ_q <= '0;
      deriv_q <= '0;
    end else begin
      prev_q  <= prev_d;
      integ_q <= integ_d;
      deriv_q <= deriv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= commanded_value_i;
      err_q <= sat_sub(commanded_value_i, measured_value_i);
    end
    case (cmd_i.op)
      OP_DIFFS: begin
        sa_q <= sat_add(err_q, prev_q);
        sd_q <= sat_sub(err_q, prev_q);
      end
      OP_ACC_TRIM: acc_q  <= sat_add(cfg_i.trim_offset, mq_q);
      OP_DHOLD:    dtmp_q <= mq_q;
      OP_ACC_INT:  acc_q  <= sat_add(acc_q, integ_q);
      OP_ACC_DER:  acc_q  <= sat_add(acc_q, deriv_q);
      OP_ACC_FF:   acc_q  <= sat_add(acc_q, mq_q);
      OP_CLAMP: begin
        if (acc_q > dmax_s) begin
          drv_q  <= cfg_i.drive_max;
          clip_q <= 1'b1;
          diff_q <= sat_sub(dmax_s, acc_q);
        end else if (acc_q < 32'sd0) begin
          drv_q  <= '0;
          clip_q <= 1'b1;
          diff_q <= sat_sub(32'sd0, acc_q);
        end else begin
          drv_q  <= acc_q[30:0];
          clip_q <= 1'b0;
          diff_q <= '0;
        end
      end
      OP_FINISH: begin
        drive_q   <= drv_q;
        clamped_q <= clip_q;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
